### hdl/hsvrgb_pkg.sv
// ----------------------------------------------------------------------------
// HSV to RGBA shared definitions
// Constants, stage payload types and the divide-by-255 helper used by the
// stages of the HSV to packed RGBA converter.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

  // Hue is unsigned Q9.7 degrees; anything above this is clamped.
  localparam logic [15:0] HUE_MAX     = 16'd46079;
  // One sector spans 60 degrees in Q9.7.
  localparam logic [15:0] SECTOR_SPAN = 16'd7680;
  // Remainder within a sector is below 7680 and fits in 13 bits.
  localparam int          REM_W       = 13;
  // The fraction is remainder / 30, done as a multiply by 2^18 / 30 rounded up.
  // The reciprocal is exact for every remainder below 10082.
  localparam int          RECIP_W     = 14;
  localparam logic [RECIP_W-1:0] FRAC_RECIP = 14'd8739;
  localparam int          FRAC_SHIFT  = 18;
  localparam int          FPROD_W     = REM_W + RECIP_W;
  localparam logic [7:0]  CHAN_MAX    = 8'd255;

  // Hue sectors, each 60 degrees wide.
  typedef enum logic [2:0] {
    SEC_RED_YELLOW   = 3'd0,
    SEC_YELLOW_GREEN = 3'd1,
    SEC_GREEN_CYAN   = 3'd2,
    SEC_CYAN_BLUE    = 3'd3,
    SEC_BLUE_MAGENTA = 3'd4,
    SEC_MAGENTA_RED  = 3'd5
  } sector_t;

  // Payload after the hue has been split into sector and fraction.
  typedef struct packed {
    sector_t    sector;
    logic [7:0] frac;
    logic [7:0] sat;
    logic [7:0] val;
    logic [7:0] alpha;
  } hue_split_t;

  // Payload after p has been formed and q, t are still raw products.
  typedef struct packed {
    sector_t     sector;
    logic [7:0]  p;
    logic [7:0]  val;
    logic [7:0]  alpha;
    logic [15:0] qprod;
    logic [15:0] tprod;
  } intens_t;

  // Exact floor(x / 255) for any product of two 8-bit values.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] sum;
    sum = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return sum[15:8];
  endfunction

endpackage

### hdl/hsv_to_packed_rgba.sv
// ----------------------------------------------------------------------------
// HSV to packed RGBA converter
// Converts one pixel of hue, saturation, value and alpha into a 32-bit word.
// ----------------------------------------------------------------------------
// The converter takes one pixel every clock cycle unless the pipeline holds,
// and returns its packed word through the six-stage pipeline, in which no
// stage holds both a multiply (8-by-8 or 13-by-14) and a divide by 255.
// While the output request is not taken the whole pipeline holds, and a new
// pixel is still accepted whenever the output register is empty or being
// taken in the same cycle. Hue is unsigned Q9.7 degrees and is clamped to
// 46079; zero saturation gives grey with alpha passed through.
module hsv_to_packed_rgba
  import hsvrgb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // Fields from bit 0: hue[15:0], saturation[23:16], brightness[31:24],
  // alpha[39:32].
  input  logic [39:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // Fields from bit 0: packed_colour[31:0].
  output logic [31:0] m_tdata
);

  logic       en;
  logic       split_valid;
  hue_split_t split;
  logic       intens_valid;
  intens_t    intens;

  // The pipeline advances unless a finished word waits at the output.
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  hsvrgb_hue_split u_hue_split (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .hue       (s_tdata[15:0]),
    .sat       (s_tdata[23:16]),
    .val       (s_tdata[31:24]),
    .alpha     (s_tdata[39:32]),
    .out_valid (split_valid),
    .out       (split)
  );

  hsvrgb_intens u_intens (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (split_valid),
    .in        (split),
    .out_valid (intens_valid),
    .out       (intens)
  );

  hsvrgb_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (intens_valid),
    .in        (intens),
    .out_valid (m_tvalid),
    .out_word  (m_tdata)
  );

  // Reset empties the pipeline, so no word appears right after it.
  assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // An accepted pixel reaches the first stage when the pipeline moves.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> $past(en))
    else $error("pixel accepted while pipeline held");

endmodule

### hdl/hsvrgb_hue_split.sv
// ----------------------------------------------------------------------------
// Hue split
// Two pipeline stages: clamp the hue and find its sector and remainder, then
// turn the remainder into an 8-bit fraction by a reciprocal multiply.
// ----------------------------------------------------------------------------
module hsvrgb_hue_split
  import hsvrgb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [15:0] hue,
  input  logic [7:0]  sat,
  input  logic [7:0]  val,
  input  logic [7:0]  alpha,
  output logic        out_valid,
  output hue_split_t  out
);

  logic [15:0]       hue_clamped;
  logic [15:0]       sector_base;
  logic [15:0]       rem_full;
  sector_t           sector_next;

  logic              s1_valid;
  sector_t           s1_sector;
  logic [REM_W-1:0]  s1_rem;
  logic [7:0]        s1_sat;
  logic [7:0]        s1_val;
  logic [7:0]        s1_alpha;

  logic [FPROD_W-1:0] frac_prod;

  // Clamp the hue and pick the sector by comparing against sector bounds.
  always_comb begin
    hue_clamped = (hue > HUE_MAX) ? HUE_MAX : hue;
    priority if (hue_clamped >= 16'(5 * SECTOR_SPAN)) begin
      sector_next = SEC_MAGENTA_RED;
      sector_base = 16'(5 * SECTOR_SPAN);
    end else if (hue_clamped >= 16'(4 * SECTOR_SPAN)) begin
      sector_next = SEC_BLUE_MAGENTA;
      sector_base = 16'(4 * SECTOR_SPAN);
    end else if (hue_clamped >= 16'(3 * SECTOR_SPAN)) begin
      sector_next = SEC_CYAN_BLUE;
      sector_base = 16'(3 * SECTOR_SPAN);
    end else if (hue_clamped >= 16'(2 * SECTOR_SPAN)) begin
      sector_next = SEC_GREEN_CYAN;
      sector_base = 16'(2 * SECTOR_SPAN);
    end else if (hue_clamped >= SECTOR_SPAN) begin
      sector_next = SEC_YELLOW_GREEN;
      sector_base = SECTOR_SPAN;
    end else begin
      sector_next = SEC_RED_YELLOW;
      sector_base = 16'd0;
    end
    rem_full = hue_clamped - sector_base;
  end

  // Stage one valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  // Stage one payload.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_sector <= sector_next;
      s1_rem    <= rem_full[REM_W-1:0];
      s1_sat    <= sat;
      s1_val    <= val;
      s1_alpha  <= alpha;
    end
  end

  // Remainder divided by 30 through the rounded-up reciprocal.
  assign frac_prod = FPROD_W'(s1_rem) * FPROD_W'(FRAC_RECIP);

  // Stage two valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s1_valid;
    end
  end

  // Stage two payload.
  always_ff @(posedge clk) begin
    if (en) begin
      out.sector <= s1_sector;
      out.frac   <= frac_prod[FRAC_SHIFT+7:FRAC_SHIFT];
      out.sat    <= s1_sat;
      out.val    <= s1_val;
      out.alpha  <= s1_alpha;
    end
  end

  // The remainder always stays inside one sector.
  assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> ({3'd0, s1_rem} < SECTOR_SPAN))
    else $error("hue remainder outside one sector");

endmodule

### hdl/hsvrgb_intens.sv
// ----------------------------------------------------------------------------
// Intensity stages
// Three pipeline stages that form p and the raw products for q and t:
// saturation products, divide by 255 with complement, then scale by value.
// ----------------------------------------------------------------------------
module hsvrgb_intens
  import hsvrgb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       in_valid,
  input  hue_split_t in,
  output logic       out_valid,
  output intens_t    out
);

  // Stage three: raw products.
  logic        s3_valid;
  sector_t     s3_sector;
  logic [7:0]  s3_val;
  logic [7:0]  s3_alpha;
  logic [15:0] s3_pprod;
  logic [15:0] s3_sfprod;
  logic [15:0] s3_snfprod;

  // Stage four: p and the complements feeding q and t.
  logic        s4_valid;
  sector_t     s4_sector;
  logic [7:0]  s4_val;
  logic [7:0]  s4_alpha;
  logic [7:0]  s4_p;
  logic [7:0]  s4_qa;
  logic [7:0]  s4_ta;

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s3_valid  <= in_valid;
      s4_valid  <= s3_valid;
      out_valid <= s4_valid;
    end
  end

  // V*(255-S), S*f and S*(255-f).
  always_ff @(posedge clk) begin
    if (en) begin
      s3_sector  <= in.sector;
      s3_val     <= in.val;
      s3_alpha   <= in.alpha;
      s3_pprod   <= 16'(in.val) * 16'(CHAN_MAX - in.sat);
      s3_sfprod  <= 16'(in.sat) * 16'(in.frac);
      s3_snfprod <= 16'(in.sat) * 16'(CHAN_MAX - in.frac);
    end
  end

  // Divide each product by 255 and take the complements for q and t.
  always_ff @(posedge clk) begin
    if (en) begin
      s4_sector <= s3_sector;
      s4_val    <= s3_val;
      s4_alpha  <= s3_alpha;
      s4_p      <= div255(s3_pprod);
      s4_qa     <= CHAN_MAX - div255(s3_sfprod);
      s4_ta     <= CHAN_MAX - div255(s3_snfprod);
    end
  end

  // Scale the complements by value.
  always_ff @(posedge clk) begin
    if (en) begin
      out.sector <= s4_sector;
      out.val    <= s4_val;
      out.alpha  <= s4_alpha;
      out.p      <= s4_p;
      out.qprod  <= 16'(s4_val) * 16'(s4_qa);
      out.tprod  <= 16'(s4_val) * 16'(s4_ta);
    end
  end

  // p is V scaled down, so it never exceeds V.
  assert property (@(posedge clk) disable iff (rst)
    s4_valid |-> (s4_p <= s4_val))
    else $error("p exceeds value");

  // S*f/255 and S*(255-f)/255 together never exceed 255.
  assert property (@(posedge clk) disable iff (rst)
    s4_valid |-> ((9'(CHAN_MAX - s4_qa) + 9'(CHAN_MAX - s4_ta)) <= 9'(CHAN_MAX)))
    else $error("q and t complements out of range");

endmodule

### hdl/hsvrgb_mix.sv
// ----------------------------------------------------------------------------
// Channel mix
// Final stage: finish q and t, route V, p, q, t to red, green and blue by
// sector, and pack the result word with alpha.
// ----------------------------------------------------------------------------
module hsvrgb_mix
  import hsvrgb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  intens_t     in,
  output logic        out_valid,
  output logic [31:0] out_word
);

  logic [7:0] q;
  logic [7:0] t;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  // Six-sector channel routing.
  always_comb begin
    q = div255(in.qprod);
    t = div255(in.tprod);
    unique case (in.sector)
      SEC_RED_YELLOW: begin
        red = in.val; green = t;      blue = in.p;
      end
      SEC_YELLOW_GREEN: begin
        red = q;      green = in.val; blue = in.p;
      end
      SEC_GREEN_CYAN: begin
        red = in.p;   green = in.val; blue = t;
      end
      SEC_CYAN_BLUE: begin
        red = in.p;   green = q;      blue = in.val;
      end
      SEC_BLUE_MAGENTA: begin
        red = t;      green = in.p;   blue = in.val;
      end
      default: begin
        red = in.val; green = in.p;   blue = q;
      end
    endcase
  end

  // Output valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // Output word.
  always_ff @(posedge clk) begin
    if (en) begin
      out_word <= {in.alpha, blue, green, red};
    end
  end

endmodule
